[sv/assert_macros.svh]
// Assertion helpers shared by the RTL modules.
// Plain text macros only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AST_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[sv/hsvbc_pkg.sv]
// Shared widths, codes, reset values and types for the HSV blob centroid block.
// No dependencies.
`default_nettype none
package hsvbc_pkg;

  localparam int HSV_W      = 8;
  localparam int POS_W      = 10;
  localparam int CNT_W      = 21;
  localparam int SUM_W      = 30;
  localparam int AREA_W     = 28;
  localparam int AREA_EXT_W = CNT_W + 8;
  localparam int BOX_W      = 3 * HSV_W;
  localparam int MINA_W     = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = BOX_W;
  localparam int SIGN_W     = 2;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [SIGN_W-1:0] SIGN_GO   = 2'd0;
  localparam logic [SIGN_W-1:0] SIGN_STOP = 2'd1;
  localparam logic [SIGN_W-1:0] SIGN_NONE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GO_LO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GO_HI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AREA = 3'd4;

  localparam logic [BOX_W-1:0]  RST_GO_LO    = 24'h326432;
  localparam logic [BOX_W-1:0]  RST_GO_HI    = 24'h64FFFF;
  localparam logic [BOX_W-1:0]  RST_STOP_LO  = 24'hA56464;
  localparam logic [BOX_W-1:0]  RST_STOP_HI  = 24'hADFFFF;
  localparam logic [MINA_W-1:0] RST_MIN_AREA = 20'd20000;

  typedef struct packed {
    logic [CNT_W-1:0] go_count;
    logic [SUM_W-1:0] go_sum_col;
    logic [SUM_W-1:0] go_sum_row;
    logic [CNT_W-1:0] stop_count;
    logic [SUM_W-1:0] stop_sum_col;
    logic [SUM_W-1:0] stop_sum_row;
  } acc_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Inclusive box test, bounds packed hue 23:16, sat 15:8, val 7:0.
  function automatic logic in_box(input logic [BOX_W-1:0] lo, input logic [BOX_W-1:0] hi,
                                  input logic [HSV_W-1:0] h, input logic [HSV_W-1:0] s,
                                  input logic [HSV_W-1:0] v);
    logic ok;
    ok = (h >= lo[23:16]) && (h <= hi[23:16]) &&
         (s >= lo[15:8])  && (s <= hi[15:8])  &&
         (v >= lo[7:0])   && (v <= hi[7:0]);
    return ok;
  endfunction

endpackage
`default_nettype wire

[sv/hsvbc_if.sv]
// Pixel and result channel interfaces, valid/ready handshake.
// Depends on hsvbc_pkg.
`default_nettype none
interface hsvbc_pix_if;
  logic                      valid;
  logic                      ready;
  logic [hsvbc_pkg::HSV_W-1:0] hue;
  logic [hsvbc_pkg::HSV_W-1:0] saturation;
  logic [hsvbc_pkg::HSV_W-1:0] brightness;
  logic [hsvbc_pkg::POS_W-1:0] col;
  logic [hsvbc_pkg::POS_W-1:0] row;
  logic                      frame_end;

  modport source (output valid, hue, saturation, brightness, col, row, frame_end,
                  input ready);
  modport sink   (input valid, hue, saturation, brightness, col, row, frame_end,
                  output ready);
endinterface

interface hsvbc_res_if;
  logic                         valid;
  logic                         ready;
  logic [hsvbc_pkg::SIGN_W-1:0] sign;
  logic [hsvbc_pkg::POS_W-1:0]  centroid_col;
  logic [hsvbc_pkg::POS_W-1:0]  centroid_row;
  logic [hsvbc_pkg::AREA_W-1:0] area;

  modport source (output valid, sign, centroid_col, centroid_row, area, input ready);
  modport sink   (input valid, sign, centroid_col, centroid_row, area, output ready);
endinterface
`default_nettype wire

[sv/hsvbc_acc.sv]
// Per-class box test and count / position-sum accumulators.
// Depends on hsvbc_pkg.
`default_nettype none
module hsvbc_acc #(
  parameter int MAX_WIDTH  = hsvbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hsvbc_pkg::DEF_MAX_HEIGHT
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            pix_beat,
  input  wire                            clear,
  input  wire [hsvbc_pkg::HSV_W-1:0]     hue,
  input  wire [hsvbc_pkg::HSV_W-1:0]     saturation,
  input  wire [hsvbc_pkg::HSV_W-1:0]     brightness,
  input  wire [hsvbc_pkg::POS_W-1:0]     col,
  input  wire [hsvbc_pkg::POS_W-1:0]     row,
  input  wire [hsvbc_pkg::BOX_W-1:0]     go_lo,
  input  wire [hsvbc_pkg::BOX_W-1:0]     go_hi,
  input  wire [hsvbc_pkg::BOX_W-1:0]     stop_lo,
  input  wire [hsvbc_pkg::BOX_W-1:0]     stop_hi,
  output hsvbc_pkg::acc_t                acc
);
  import hsvbc_pkg::*;

  acc_t acc_r, acc_nxt;
  logic in_frame, go_hit, stop_hit;

  assign in_frame = ({22'd0, col} < 32'(MAX_WIDTH)) && ({22'd0, row} < 32'(MAX_HEIGHT));
  assign go_hit   = pix_beat && in_frame && in_box(go_lo, go_hi, hue, saturation, brightness);
  assign stop_hit = pix_beat && in_frame &&
                    in_box(stop_lo, stop_hi, hue, saturation, brightness);

  always_comb begin
    acc_nxt = acc_r;
    if (clear) begin
      acc_nxt = '0;
    end else begin
      if (go_hit) begin
        acc_nxt.go_count   = acc_r.go_count + CNT_W'(1);
        acc_nxt.go_sum_col = acc_r.go_sum_col + SUM_W'(col);
        acc_nxt.go_sum_row = acc_r.go_sum_row + SUM_W'(row);
      end
      if (stop_hit) begin
        acc_nxt.stop_count   = acc_r.stop_count + CNT_W'(1);
        acc_nxt.stop_sum_col = acc_r.stop_sum_col + SUM_W'(col);
        acc_nxt.stop_sum_row = acc_r.stop_sum_row + SUM_W'(row);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

[sv/hsvbc_div.sv]
// Shared restoring divider, one quotient bit per cycle, quotient clamped to 1023.
// Depends on hsvbc_pkg and assert_macros.svh.
`default_nettype none
module hsvbc_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [hsvbc_pkg::SUM_W-1:0]   dividend,
  input  wire [hsvbc_pkg::CNT_W-1:0]   divisor,
  output hsvbc_pkg::div_status_t       status,
  output logic [hsvbc_pkg::POS_W-1:0]  quotient
);
  import hsvbc_pkg::*;
  `include "assert_macros.svh"

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W:0]    shifted;
  logic [CNT_W-1:0]  diff;
  logic              fits;

  // remainder stays below the divisor, so one extra bit covers the shift
  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign diff    = shifted[CNT_W-1:0] - dvs_r;
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[SUM_W-2:0], fits};
      rem_nxt  = fits ? diff : shifted[CNT_W-1:0];
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = (|quo_r[SUM_W-1:POS_W]) ? {POS_W{1'b1}} : quo_r[POS_W-1:0];

  `AST_SAME(a_no_restart, clk, rst_n, start, !busy_r)
  `AST_SAME(a_done_idle, clk, rst_n, done_r, !busy_r)
  `AST_NEXT(a_busy_ends_in_done, clk, rst_n, busy_r && !start, busy_r || done_r)

endmodule
`default_nettype wire

[sv/hsv_two_class_blob_centroid.sv]
// Top level: configuration registers, class choice sequencer and result register.
// Depends on hsvbc_pkg, hsvbc_if, hsvbc_acc, hsvbc_div and assert_macros.svh.
//
//   port     dir   role
//   in_pix   sink  pixel beats: hue, saturation, brightness, col, row, frame_end
//   out_res  src   one beat per frame: sign, centroid_col, centroid_row, area
//   cfg_*    in    register write: cfg_we, cfg_idx, cfg_wdata
//
// Ordinary pixels are accepted while idle. A frame_end pixel starts the
// sequencer: pick the class, then column and row centroids in the shared
// serial divider, then load the result register (straight after the pick when
// no class qualifies). in_pix.ready is low for that time and while the result
// register still holds an untaken beat at the end. Reset is synchronous.
`default_nettype none
module hsv_two_class_blob_centroid #(
  parameter int MAX_WIDTH  = hsvbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hsvbc_pkg::DEF_MAX_HEIGHT
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  hsvbc_pix_if.sink                           in_pix,
  hsvbc_res_if.source                         out_res,
  input  wire                                 cfg_we,
  input  wire [hsvbc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire [hsvbc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import hsvbc_pkg::*;
  `include "assert_macros.svh"

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DECIDE  = 3'd1;
  localparam logic [2:0] ST_DIV_COL = 3'd2;
  localparam logic [2:0] ST_DIV_ROW = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  logic [2:0] state_r, state_nxt;

  logic [BOX_W-1:0]  go_lo_r, go_hi_r, stop_lo_r, stop_hi_r;
  logic [MINA_W-1:0] min_area_r;

  acc_t        acc;
  div_status_t div_st;
  logic [POS_W-1:0] div_q;
  logic        pix_beat, acc_clear, div_start;
  logic [SUM_W-1:0] div_dividend;
  logic [CNT_W-1:0] div_divisor;

  logic [AREA_EXT_W-1:0] go_area, stop_area, min_ext, pick_area;
  logic go_q, stop_q, pick_stop, pick_none;
  logic [CNT_W-1:0] pick_count;

  logic [SIGN_W-1:0] sel_sign_r, sel_sign_nxt;
  logic [AREA_W-1:0] sel_area_r, sel_area_nxt;
  logic [CNT_W-1:0]  sel_count_r, sel_count_nxt;
  logic [SUM_W-1:0]  sel_sum_row_r, sel_sum_row_nxt;
  logic [POS_W-1:0]  cent_col_r, cent_col_nxt;
  logic [POS_W-1:0]  cent_row_r, cent_row_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [SIGN_W-1:0] out_sign_r, out_sign_nxt;
  logic [POS_W-1:0]  out_col_r, out_col_nxt;
  logic [POS_W-1:0]  out_row_r, out_row_nxt;
  logic [AREA_W-1:0] out_area_r, out_area_nxt;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_lo_r    <= RST_GO_LO;
      go_hi_r    <= RST_GO_HI;
      stop_lo_r  <= RST_STOP_LO;
      stop_hi_r  <= RST_STOP_HI;
      min_area_r <= RST_MIN_AREA;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_GO_LO:    go_lo_r    <= cfg_wdata;
        CFG_GO_HI:    go_hi_r    <= cfg_wdata;
        CFG_STOP_LO:  stop_lo_r  <= cfg_wdata;
        CFG_STOP_HI:  stop_hi_r  <= cfg_wdata;
        CFG_MIN_AREA: min_area_r <= cfg_wdata[MINA_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_pix.ready = (state_r == ST_IDLE);
  assign pix_beat     = in_pix.valid && in_pix.ready;

  hsvbc_acc #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_beat  (pix_beat),
    .clear     (acc_clear),
    .hue       (in_pix.hue),
    .saturation(in_pix.saturation),
    .brightness(in_pix.brightness),
    .col       (in_pix.col),
    .row       (in_pix.row),
    .go_lo     (go_lo_r),
    .go_hi     (go_hi_r),
    .stop_lo   (stop_lo_r),
    .stop_hi   (stop_hi_r),
    .acc       (acc)
  );

  hsvbc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .status  (div_st),
    .quotient(div_q)
  );

  // area = 255 * count
  assign go_area   = {acc.go_count, 8'd0} - AREA_EXT_W'(acc.go_count);
  assign stop_area = {acc.stop_count, 8'd0} - AREA_EXT_W'(acc.stop_count);
  assign min_ext   = AREA_EXT_W'(min_area_r);
  assign go_q      = (go_area > min_ext) && (go_area > AREA_EXT_W'(1));
  assign stop_q    = (stop_area > min_ext) && (stop_area > AREA_EXT_W'(1));
  // stop displaces go only with a strictly larger area
  assign pick_stop = stop_q && (!go_q || (stop_area > go_area));
  assign pick_none = !go_q && !stop_q;
  assign pick_count = pick_stop ? acc.stop_count : acc.go_count;
  assign pick_area  = pick_stop ? stop_area : go_area;

  always_comb begin
    state_nxt       = state_r;
    acc_clear       = 1'b0;
    div_start       = 1'b0;
    div_dividend    = sel_sum_row_r;
    div_divisor     = sel_count_r;
    sel_sign_nxt    = sel_sign_r;
    sel_area_nxt    = sel_area_r;
    sel_count_nxt   = sel_count_r;
    sel_sum_row_nxt = sel_sum_row_r;
    cent_col_nxt    = cent_col_r;
    cent_row_nxt    = cent_row_r;
    out_valid_nxt   = out_valid_r && !out_res.ready;
    out_sign_nxt    = out_sign_r;
    out_col_nxt     = out_col_r;
    out_row_nxt     = out_row_r;
    out_area_nxt    = out_area_r;
    case (state_r)
      ST_IDLE: begin
        if (pix_beat && in_pix.frame_end) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        acc_clear       = 1'b1;
        sel_count_nxt   = pick_count;
        sel_sum_row_nxt = pick_stop ? acc.stop_sum_row : acc.go_sum_row;
        if (pick_none) begin
          sel_sign_nxt = SIGN_NONE;
          sel_area_nxt = '0;
          cent_col_nxt = '0;
          cent_row_nxt = '0;
          state_nxt    = ST_DONE;
        end else begin
          sel_sign_nxt = pick_stop ? SIGN_STOP : SIGN_GO;
          sel_area_nxt = pick_area[AREA_EXT_W-1] ? {AREA_W{1'b1}} : pick_area[AREA_W-1:0];
          div_start    = 1'b1;
          div_dividend = pick_stop ? acc.stop_sum_col : acc.go_sum_col;
          div_divisor  = pick_count;
          state_nxt    = ST_DIV_COL;
        end
      end
      ST_DIV_COL: begin
        if (div_st.done) begin
          cent_col_nxt = div_q;
          div_start    = 1'b1;
          state_nxt    = ST_DIV_ROW;
        end
      end
      ST_DIV_ROW: begin
        if (div_st.done) begin
          cent_row_nxt = div_q;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          out_sign_nxt  = sel_sign_r;
          out_col_nxt   = cent_col_r;
          out_row_nxt   = cent_row_r;
          out_area_nxt  = sel_area_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_sign_r    <= sel_sign_nxt;
    sel_area_r    <= sel_area_nxt;
    sel_count_r   <= sel_count_nxt;
    sel_sum_row_r <= sel_sum_row_nxt;
    cent_col_r    <= cent_col_nxt;
    cent_row_r    <= cent_row_nxt;
    out_sign_r    <= out_sign_nxt;
    out_col_r     <= out_col_nxt;
    out_row_r     <= out_row_nxt;
    out_area_r    <= out_area_nxt;
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.sign         = out_sign_r;
  assign out_res.centroid_col = out_col_r;
  assign out_res.centroid_row = out_row_r;
  assign out_res.area         = out_area_r;

  `AST_NEXT(a_frame_end_decides, clk, rst_n, pix_beat && in_pix.frame_end, state_r == ST_DECIDE)
  `AST_NEXT(a_acc_cleared, clk, rst_n, state_r == ST_DECIDE,
            acc.go_count == '0 && acc.stop_count == '0)
  `AST_SAME(a_div_idle_when_ready, clk, rst_n, state_r == ST_IDLE, !div_st.busy)
  `AST_SAME(a_none_zero_area, clk, rst_n, state_r == ST_DONE && sel_sign_r == SIGN_NONE,
            sel_area_r == '0)

endmodule
`default_nettype wire

[tb/sv/tb_hsv_two_class_blob_centroid.sv]
// Self-checking bench for hsv_two_class_blob_centroid: directed and random HSV pixel frames
// under several box / area settings, each frame result checked against a predictor.
// Depends on hsvbc_pkg, hsvbc_if and the block's RTL.
`default_nettype none
module tb_hsv_two_class_blob_centroid;
  timeunit 1ns;
  timeprecision 1ps;
  import hsvbc_pkg::*;

  localparam int     SETTLE     = 100;
  localparam int     DRAIN_MAX  = 20000;
  localparam longint AREA_SAT   = (longint'(1) << AREA_W) - 1;

  typedef struct packed {
    logic [HSV_W-1:0] hue;
    logic [HSV_W-1:0] sat;
    logic [HSV_W-1:0] bri;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last;
  } pixel_t;

  typedef struct packed {
    logic [SIGN_W-1:0] sign;
    logic [POS_W-1:0]  ccol;
    logic [POS_W-1:0]  crow;
    logic [AREA_W-1:0] area;
  } frame_result_t;

  // Class index doubles as its sign code: go 0, stop 1.
  class blob_scoreboard;
    logic [BOX_W-1:0]  lo_bound[2];
    logic [BOX_W-1:0]  hi_bound[2];
    logic [MINA_W-1:0] area_floor;
    logic [CNT_W-1:0]  hits[2];
    logic [SUM_W-1:0]  col_sum[2];
    logic [SUM_W-1:0]  row_sum[2];
    frame_result_t     expected_frames[$];
    int                errors;
    int                pixels;
    int                frames;

    function new();
      lo_bound[SIGN_GO]   = RST_GO_LO;
      hi_bound[SIGN_GO]   = RST_GO_HI;
      lo_bound[SIGN_STOP] = RST_STOP_LO;
      hi_bound[SIGN_STOP] = RST_STOP_HI;
      area_floor          = RST_MIN_AREA;
      clear_sums();
      errors = 0;
      pixels = 0;
      frames = 0;
    endfunction

    function void clear_sums();
      for (int c = 0; c < 2; c++) begin
        hits[c]    = '0;
        col_sum[c] = '0;
        row_sum[c] = '0;
      end
    endfunction

    function void write_reg(int idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GO_LO:    lo_bound[SIGN_GO]   = data;
        CFG_GO_HI:    hi_bound[SIGN_GO]   = data;
        CFG_STOP_LO:  lo_bound[SIGN_STOP] = data;
        CFG_STOP_HI:  hi_bound[SIGN_STOP] = data;
        CFG_MIN_AREA: area_floor          = data[MINA_W-1:0];
        default: ;
      endcase
    endfunction

    function bit in_class(int c, pixel_t p);
      return p.hue >= lo_bound[c][16 +: 8] && p.hue <= hi_bound[c][16 +: 8] &&
             p.sat >= lo_bound[c][8 +: 8]  && p.sat <= hi_bound[c][8 +: 8]  &&
             p.bri >= lo_bound[c][0 +: 8]  && p.bri <= hi_bound[c][0 +: 8];
    endfunction

    function logic [POS_W-1:0] centroid(logic [SUM_W-1:0] sum, logic [CNT_W-1:0] n);
      logic [SUM_W-1:0] q;
      q = sum / n;
      return (q > 1023) ? '1 : q[POS_W-1:0];
    endfunction

    function void note_pixel(pixel_t p);
      longint            area_of[2];
      longint            best;
      logic [SIGN_W-1:0] pick;
      frame_result_t     r;
      pixels++;
      if (p.col < DEF_MAX_WIDTH && p.row < DEF_MAX_HEIGHT) begin
        for (int c = 0; c < 2; c++) begin
          if (in_class(c, p)) begin
            hits[c]    += CNT_W'(1);
            col_sum[c] += SUM_W'(p.col);
            row_sum[c] += SUM_W'(p.row);
          end
        end
      end
      if (!p.last) return;
      // go is looked at first, stop needs a strictly larger area
      best = 1;
      pick = SIGN_NONE;
      for (int c = 0; c < 2; c++) begin
        area_of[c] = 255 * longint'(hits[c]);
        if (area_of[c] > area_floor && area_of[c] > best) begin
          best = area_of[c];
          pick = c[SIGN_W-1:0];
        end
      end
      r.sign = pick;
      if (pick == SIGN_NONE) begin
        r.ccol = '0;
        r.crow = '0;
        r.area = '0;
      end else begin
        r.ccol = centroid(col_sum[pick], hits[pick]);
        r.crow = centroid(row_sum[pick], hits[pick]);
        r.area = (best > AREA_SAT) ? '1 : best[AREA_W-1:0];
      end
      expected_frames.push_back(r);
      clear_sums();
    endfunction

    function void mismatch(string what, longint want, longint got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (expected_frames.size() == 0) begin
        mismatch("unexpected beat, sign", -1, got.sign);
        return;
      end
      want = expected_frames.pop_front();
      frames++;
      if (got.sign !== want.sign) mismatch("sign", want.sign, got.sign);
      if (got.ccol !== want.ccol) mismatch("centroid_col", want.ccol, got.ccol);
      if (got.crow !== want.crow) mismatch("centroid_row", want.crow, got.crow);
      if (got.area !== want.area) mismatch("area", want.area, got.area);
    endfunction

    function void report_leftovers();
      if (expected_frames.size() != 0)
        mismatch("frames still outstanding, count", 0, expected_frames.size());
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    calm;
  int                    settings_used;
  blob_scoreboard        sb;

  hsvbc_pix_if in_pix();
  hsvbc_res_if out_res();

  hsv_two_class_blob_centroid u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb_hsv_two_class_blob_centroid: errors");
    $finish;
  end

  function automatic logic [HSV_W-1:0] pick_level(logic [HSV_W-1:0] lo, logic [HSV_W-1:0] hi);
    return (lo <= hi) ? HSV_W'($urandom_range(hi, lo)) : HSV_W'($urandom_range(255, 0));
  endfunction

  function automatic pixel_t pix(int h, int s, int v, int c, int r, bit last);
    pixel_t p;
    p.hue  = HSV_W'(h);
    p.sat  = HSV_W'(s);
    p.bri  = HSV_W'(v);
    p.col  = POS_W'(c);
    p.row  = POS_W'(r);
    p.last = last;
    return p;
  endfunction

  // Mostly pixels aimed inside one of the boxes, the rest anywhere.
  function automatic pixel_t draw_pixel(bit last);
    pixel_t p;
    int     pick;
    int     c;
    pick = $urandom_range(9, 0);
    c    = (pick < 4) ? int'(SIGN_GO) : int'(SIGN_STOP);
    p = pix($urandom_range(255, 0), $urandom_range(255, 0), $urandom_range(255, 0),
            $urandom_range(1023, 0), $urandom_range(1023, 0), last);
    if (pick < 8) begin
      p.hue = pick_level(sb.lo_bound[c][16 +: 8], sb.hi_bound[c][16 +: 8]);
      p.sat = pick_level(sb.lo_bound[c][8 +: 8], sb.hi_bound[c][8 +: 8]);
      p.bri = pick_level(sb.lo_bound[c][0 +: 8], sb.hi_bound[c][0 +: 8]);
    end
    return p;
  endfunction

  function automatic void random_box(output logic [BOX_W-1:0] lo, output logic [BOX_W-1:0] hi);
    for (int k = 0; k < 3; k++) begin
      lo[8*k +: 8] = 8'($urandom_range(255, 0));
      hi[8*k +: 8] = ($urandom_range(7, 0) == 0) ? 8'($urandom_range(255, 0))
                                                 : 8'($urandom_range(255, lo[8*k +: 8]));
    end
  endfunction

  // Writes all registers plus the unused indexes, which must be ignored.
  task automatic program_regs(logic [BOX_W-1:0] go_lo, logic [BOX_W-1:0] go_hi,
                              logic [BOX_W-1:0] st_lo, logic [BOX_W-1:0] st_hi,
                              logic [MINA_W-1:0] floor_val);
    logic [CFG_DATA_W-1:0] vals[5];
    logic [CFG_DATA_W-1:0] word;
    vals[CFG_GO_LO]   = go_lo;
    vals[CFG_GO_HI]   = go_hi;
    vals[CFG_STOP_LO] = st_lo;
    vals[CFG_STOP_HI] = st_hi;
    for (int k = 0; k < (1 << CFG_IDX_W); k++) begin
      if (k < CFG_MIN_AREA)
        word = vals[k];
      else if (k == CFG_MIN_AREA)
        word = {4'($urandom_range(15, 0)), floor_val};
      else
        word = CFG_DATA_W'($urandom);
      cfg_we    <= 1'b1;
      cfg_idx   <= k[CFG_IDX_W-1:0];
      cfg_wdata <= word;
      sb.write_reg(k, word);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_pixel(pixel_t p);
    int gap;
    gap = calm ? 0 : $urandom_range(9, 0);
    if (gap != 0) begin
      in_pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pix.valid      <= 1'b1;
    in_pix.hue        <= p.hue;
    in_pix.saturation <= p.sat;
    in_pix.brightness <= p.bri;
    in_pix.col        <= p.col;
    in_pix.row        <= p.row;
    in_pix.frame_end  <= p.last;
    do @(posedge clk); while (in_pix.ready !== 1'b1);
    sb.note_pixel(p);
  endtask

  // Sender holds off until every frame result is back, then lets the divider settle.
  task automatic settle();
    int waited;
    waited = 0;
    in_pix.valid <= 1'b0;
    while (sb.expected_frames.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_frames(int budget, int min_len, int max_len);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      len  = $urandom_range(max_len, min_len);
      calm = ($urandom_range(3, 0) == 0);
      for (int i = 0; i < len; i++) send_pixel(draw_pixel(i == len - 1));
      sent += len;
    end
    settle();
  endtask

  task automatic take_results();
    int            stall;
    frame_result_t got;
    forever begin
      stall = calm ? 0 : $urandom_range(9, 0);
      if (stall != 0) begin
        out_res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_res.ready <= 1'b1;
      do @(posedge clk); while (out_res.valid !== 1'b1);
      got.sign = out_res.sign;
      got.ccol = out_res.centroid_col;
      got.crow = out_res.centroid_row;
      got.area = out_res.area;
      sb.check_result(got);
    end
  endtask

  initial begin
    logic [BOX_W-1:0] glo, ghi, slo, shi;
    sb            = new();
    calm          = 1'b0;
    settings_used = 0;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= '0;
    cfg_wdata         <= '0;
    in_pix.valid      <= 1'b0;
    in_pix.hue        <= '0;
    in_pix.saturation <= '0;
    in_pix.brightness <= '0;
    in_pix.col        <= '0;
    in_pix.row        <= '0;
    in_pix.frame_end  <= 1'b0;
    out_res.ready     <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    fork
      take_results();
    join_none

    // Directed: hue splits the classes, any single pixel qualifies.
    program_regs(24'h000000, 24'h7FFFFF, 24'h800000, 24'hF0FFFF, '0);
    send_pixel(pix(8'h00, 8'h00, 8'h00, 0, 0, 1));
    send_pixel(pix(8'hFF, 8'hFF, 8'hFF, 1023, 1023, 1));     // in neither box
    send_pixel(pix(8'h7F, 8'h00, 8'hFF, 1023, 0, 0));        // equal areas: go holds
    send_pixel(pix(8'h80, 8'hFF, 8'h00, 0, 1023, 1));
    send_pixel(pix(8'h10, 8'h55, 8'hAA, 5, 7, 0));
    send_pixel(pix(8'hA0, 8'hAA, 8'h55, 100, 200, 0));
    send_pixel(pix(8'hF0, 8'h01, 8'hFE, 301, 400, 1));
    send_pixel(pix(8'h20, 8'h80, 8'h7F, 3, 4, 0));
    send_pixel(pix(8'h21, 8'h7F, 8'h80, 4, 4, 0));
    send_pixel(pix(8'hC0, 8'hFE, 8'h01, 500, 500, 1));
    settle();
    // Empty go box (hue low above high), high area threshold.
    program_regs(24'h900000, 24'h10FFFF, 24'h800000, 24'hFFFFFF, 20'd1000000);
    send_pixel(pix(8'hFF, 8'hFF, 8'hFF, 512, 511, 0));
    send_pixel(pix(8'h95, 8'h00, 8'h00, 1, 2, 0));
    send_pixel(pix(8'h05, 8'h33, 8'hCC, 1022, 1, 1));
    settle();

    program_regs(RST_GO_LO, RST_GO_HI, RST_STOP_LO, RST_STOP_HI, RST_MIN_AREA);
    run_frames(350, 60, 200);
    random_box(slo, shi);
    program_regs(24'h000000, 24'hFFFFFF, slo, shi, '0);
    run_frames(250, 1, 12);
    random_box(glo, ghi);
    program_regs(glo, ghi, glo, ghi, 20'd255);
    run_frames(250, 1, 20);
    random_box(glo, ghi);
    random_box(slo, shi);
    program_regs(glo, ghi, slo, shi, 20'd1000000);
    run_frames(200, 1, 30);
    random_box(glo, ghi);
    random_box(slo, shi);
    program_regs(glo, ghi, slo, shi, 20'd1000);
    run_frames(250, 1, 25);
    random_box(glo, ghi);
    random_box(slo, shi);
    program_regs(glo, ghi, slo, shi, 20'($urandom_range(4000, 0)));
    run_frames(300, 1, 40);
    random_box(glo, ghi);
    random_box(slo, shi);
    program_regs(glo, ghi, slo, shi, 20'd1);
    run_frames(250, 1, 8);

    sb.report_leftovers();
    $display("%0d pixels driven under %0d register settings", sb.pixels, settings_used);
    $display("%0d frame results compared, %0d mismatches", sb.frames, sb.errors);
    if (sb.errors == 0)
      $display("tb_hsv_two_class_blob_centroid: clean");
    else
      $display("tb_hsv_two_class_blob_centroid: errors");
    $finish;
  end

endmodule
`default_nettype wire
